>>> rtl/aalr_pkg.sv
// ----------------------------------------------------------------------------
// aalr_pkg: shared types and constants of the anti-aliased line rasterizer
// Grid size, field widths, controller states, command/status bundles and the
// small arithmetic helpers used by the datapath.
// ----------------------------------------------------------------------------
package aalr_pkg;

  localparam int GRID_SIZE  = 40;
  localparam int COORD_W    = 6;
  localparam int COL_W      = 8;
  localparam int COV_W      = 8;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = COL_W + COV_W;
  localparam int DIVIDEND_W = COORD_W + FRAC_W;
  localparam int QUO_W      = FRAC_W + 1;
  localparam int GRAD_W     = QUO_W + 1;
  localparam int POS_W      = COORD_W + FRAC_W + 1;
  localparam int CNT_W      = $clog2(DIVIDEND_W + 1);

  localparam logic [COV_W-1:0]   COV_HALF  = COV_W'(127);
  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);
  localparam logic [COORD_W:0]   GRID_LIM  = (COORD_W + 1)'(GRID_SIZE);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COL_W-1:0]   chan_t;
  typedef logic [COV_W-1:0]   cov_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  typedef struct packed {
    coord_t major;
    coord_t minor;
    cov_t   cov1;
    cov_t   cov2;
    logic   last;
  } pair_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_EMIT_FIRST,
    ST_EMIT_SECOND,
    ST_INTERIOR,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic emit_first;
    logic emit_second;
    logic emit_interior;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic len_le1;
    logic div_done;
    logic interior_last;
    logic pipe_busy;
  } status_t;

  // Clamp a coordinate to the last grid column/row.
  function automatic coord_t sat_coord(coord_t c);
    return (c > COORD_MAX) ? COORD_MAX : c;
  endfunction

  // floor(x / 255) for any product of two 8-bit values, by add and shift.
  function automatic chan_t div255(logic [PROD_W-1:0] x);
    logic [PROD_W:0] s;
    s = {1'b0, x} + (PROD_W + 1)'(x >> COL_W) + (PROD_W + 1)'(1);
    return chan_t'(s >> COL_W);
  endfunction

endpackage

>>> rtl/aalr_div.sv
// ----------------------------------------------------------------------------
// aalr_div: radix-2 restoring divider
// Produces one quotient bit per cycle; done pulses once when the quotient
// register holds the final value.
// ----------------------------------------------------------------------------
module aalr_div import aalr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  coord_t                divisor_i,
  output logic                  done_o,
  output logic [QUO_W-1:0]      quotient_o
);

  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  coord_t                rem_q, rem_d;
  coord_t                dvs_q;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [COORD_W:0]      trial;
  logic [COORD_W:0]      diff;
  logic                  fits;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(DIVIDEND_W);
    end else if (run_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
    end else if (run_q) begin
      rem_d = fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[QUO_W-1:0];

endmodule

>>> rtl/aalr_shade.sv
// ----------------------------------------------------------------------------
// aalr_shade: pixel-pair shading pipeline
// Places the pair on the grid, checks coverage and bounds, scales the colour
// by coverage/255 and registers the result word. Two stages.
// ----------------------------------------------------------------------------
module aalr_shade import aalr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   pair_valid_i,
  input  pair_t  pair_i,
  input  logic   steep_i,
  input  rgb_t   color_i,
  output logic   busy_o,
  output logic   valid_o,
  output coord_t pix_x_o,
  output coord_t pix_y_o,
  output logic   steep_o,
  output logic   write_first_o,
  output logic   write_second_o,
  output rgb_t   first_o,
  output rgb_t   second_o,
  output logic   last_o
);

  coord_t           px, py;
  logic [COORD_W:0] qx, qy;
  logic             w1, w2;

  logic              s1_valid_q;
  coord_t            s1_px_q, s1_py_q;
  logic              s1_steep_q, s1_last_q, s1_w1_q, s1_w2_q;
  logic [PROD_W-1:0] s1_p1_q [3];
  logic [PROD_W-1:0] s1_p2_q [3];

  logic   out_valid_q;
  coord_t out_px_q, out_py_q;
  logic   out_steep_q, out_last_q, out_w1_q, out_w2_q;
  rgb_t   out_c1_q, out_c2_q;

  // Second pixel sits one step past the first across the minor axis.
  always_comb begin
    px = steep_i ? pair_i.minor : pair_i.major;
    py = steep_i ? pair_i.major : pair_i.minor;
    qx = steep_i ? {1'b0, px} + (COORD_W + 1)'(1) : {1'b0, px};
    qy = steep_i ? {1'b0, py} : {1'b0, py} + (COORD_W + 1)'(1);
    w1 = (pair_i.cov1 != '0) && ({1'b0, px} < GRID_LIM) && ({1'b0, py} < GRID_LIM);
    w2 = (pair_i.cov2 != '0) && (qx < GRID_LIM) && (qy < GRID_LIM);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= pair_valid_i;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_px_q    <= px;
    s1_py_q    <= py;
    s1_steep_q <= steep_i;
    s1_last_q  <= pair_i.last;
    s1_w1_q    <= w1;
    s1_w2_q    <= w2;
    s1_p1_q[0] <= PROD_W'(color_i.red)   * PROD_W'(pair_i.cov1);
    s1_p1_q[1] <= PROD_W'(color_i.green) * PROD_W'(pair_i.cov1);
    s1_p1_q[2] <= PROD_W'(color_i.blue)  * PROD_W'(pair_i.cov1);
    s1_p2_q[0] <= PROD_W'(color_i.red)   * PROD_W'(pair_i.cov2);
    s1_p2_q[1] <= PROD_W'(color_i.green) * PROD_W'(pair_i.cov2);
    s1_p2_q[2] <= PROD_W'(color_i.blue)  * PROD_W'(pair_i.cov2);

    out_px_q       <= s1_px_q;
    out_py_q       <= s1_py_q;
    out_steep_q    <= s1_steep_q;
    out_last_q     <= s1_last_q;
    out_w1_q       <= s1_w1_q;
    out_w2_q       <= s1_w2_q;
    // Drop colour of unwritten pixels.
    out_c1_q.red   <= s1_w1_q ? div255(s1_p1_q[0]) : '0;
    out_c1_q.green <= s1_w1_q ? div255(s1_p1_q[1]) : '0;
    out_c1_q.blue  <= s1_w1_q ? div255(s1_p1_q[2]) : '0;
    out_c2_q.red   <= s1_w2_q ? div255(s1_p2_q[0]) : '0;
    out_c2_q.green <= s1_w2_q ? div255(s1_p2_q[1]) : '0;
    out_c2_q.blue  <= s1_w2_q ? div255(s1_p2_q[2]) : '0;
  end

  assign busy_o         = s1_valid_q;
  assign valid_o        = out_valid_q;
  assign pix_x_o        = out_px_q;
  assign pix_y_o        = out_py_q;
  assign steep_o        = out_steep_q;
  assign write_first_o  = out_valid_q & out_w1_q;
  assign write_second_o = out_valid_q & out_w2_q;
  assign first_o        = out_c1_q;
  assign second_o       = out_c2_q;
  assign last_o         = out_last_q;

endmodule

>>> rtl/aalr_datapath.sv
// ----------------------------------------------------------------------------
// aalr_datapath: endpoint setup, gradient, minor-axis stepping and shading
// Orders the endpoints at load, divides for the gradient, walks the interior
// steps in 6.16 fixed point and feeds pixel pairs to the shading pipeline.
// ----------------------------------------------------------------------------
module aalr_datapath import aalr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  output status_t status_o,
  input  coord_t  x_start_i,
  input  coord_t  y_start_i,
  input  coord_t  x_stop_i,
  input  coord_t  y_stop_i,
  input  chan_t   red_i,
  input  chan_t   green_i,
  input  chan_t   blue_i,
  output logic    valid_o,
  output coord_t  pix_x_o,
  output coord_t  pix_y_o,
  output logic    steep_o,
  output logic    write_first_o,
  output logic    write_second_o,
  output rgb_t    first_o,
  output rgb_t    second_o,
  output logic    last_o
);

  // Load-time setup
  coord_t           x0, y0, x1, y1;
  logic [COORD_W:0] dx, dy;
  coord_t           adx, ady;
  logic             steep;
  coord_t           a0, n0, a1, n1;
  coord_t           ma0, mi0, ma1, mi1;
  logic [COORD_W:0] dmin;

  logic   steep_q;
  coord_t ma0_q, mi0_q, ma1_q, mi1_q, len_q;
  logic   dneg_q;
  coord_t dabs_q;
  rgb_t   color_q;

  // Gradient and stepping
  logic                  div_done;
  logic [QUO_W-1:0]      quotient;
  logic [GRAD_W-1:0]     grad;
  logic [POS_W-1:0]      pos_q, pos_d;
  coord_t                k_q, k_d;
  logic [FRAC_W-1:0]     frac;
  logic [FRAC_W:0]       frac_inv;
  logic [FRAC_W+COV_W:0] t1;
  logic [FRAC_W+COV_W:0] t2;
  cov_t                  c1, c2;

  // Issue stage
  logic   issue_valid_q;
  pair_t  issue_q, issue_d;
  coord_t first_major;
  logic   shade_busy;

  always_comb begin
    x0    = sat_coord(x_start_i);
    y0    = sat_coord(y_start_i);
    x1    = sat_coord(x_stop_i);
    y1    = sat_coord(y_stop_i);
    dx    = {1'b0, x1} - {1'b0, x0};
    dy    = {1'b0, y1} - {1'b0, y0};
    adx   = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ady   = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    steep = adx <= ady;
    a0    = steep ? y0 : x0;
    n0    = steep ? x0 : y0;
    a1    = steep ? y1 : x1;
    n1    = steep ? x1 : y1;
    // Order so the major coordinate does not decrease.
    if (a1 < a0) begin
      ma0 = a1; mi0 = n1; ma1 = a0; mi1 = n0;
    end else begin
      ma0 = a0; mi0 = n0; ma1 = a1; mi1 = n1;
    end
    dmin = {1'b0, mi1} - {1'b0, mi0};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      steep_q       <= steep;
      ma0_q         <= ma0;
      mi0_q         <= mi0;
      ma1_q         <= ma1;
      mi1_q         <= mi1;
      len_q         <= ma1 - ma0;
      dneg_q        <= dmin[COORD_W];
      dabs_q        <= dmin[COORD_W] ? COORD_W'(-dmin) : dmin[COORD_W-1:0];
      color_q.red   <= red_i;
      color_q.green <= green_i;
      color_q.blue  <= blue_i;
    end
  end

  aalr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({dabs_q, {FRAC_W{1'b0}}}),
    .divisor_i  (len_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Gradient truncates toward zero: divide magnitudes, then apply sign.
  assign grad = dneg_q ? GRAD_W'(0) - {1'b0, quotient} : {1'b0, quotient};

  // Coverage from the fractional minor position.
  always_comb begin
    frac     = pos_q[FRAC_W-1:0];
    frac_inv = (FRAC_W + 1)'(1) << FRAC_W;
    frac_inv = frac_inv - {1'b0, frac};
    t1       = {frac_inv, {COV_W{1'b0}}} - (FRAC_W + COV_W + 1)'(frac_inv);
    t2       = {1'b0, frac, {COV_W{1'b0}}} - (FRAC_W + COV_W + 1)'(frac);
    c1       = t1[FRAC_W +: COV_W];
    c2       = t2[FRAC_W +: COV_W];
  end

  assign first_major = (len_q != '0) ? ma0_q :
                       (ma0_q != '0) ? ma0_q - COORD_W'(1) : '0;

  always_comb begin
    pos_d   = pos_q;
    k_d     = k_q;
    issue_d = issue_q;
    if (cmd_i.emit_first) begin
      issue_d = '{major: first_major, minor: mi0_q, cov1: COV_HALF, cov2: '0,
                  last: 1'b0};
      pos_d   = {1'b0, mi0_q, {FRAC_W{1'b0}}}
              + {{(POS_W - GRAD_W){grad[GRAD_W-1]}}, grad};
      k_d     = COORD_W'(1);
    end else if (cmd_i.emit_second) begin
      issue_d = '{major: ma1_q, minor: mi1_q, cov1: COV_HALF, cov2: '0,
                  last: status_o.len_le1};
    end else if (cmd_i.emit_interior) begin
      issue_d = '{major: ma0_q + k_q, minor: pos_q[FRAC_W +: COORD_W],
                  cov1: c1, cov2: c2, last: status_o.interior_last};
      pos_d   = pos_q + {{(POS_W - GRAD_W){grad[GRAD_W-1]}}, grad};
      k_d     = k_q + COORD_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_valid_q <= 1'b0;
    end else begin
      issue_valid_q <= cmd_i.emit_first | cmd_i.emit_second | cmd_i.emit_interior;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    k_q     <= k_d;
    issue_q <= issue_d;
  end

  aalr_shade u_shade (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pair_valid_i   (issue_valid_q),
    .pair_i         (issue_q),
    .steep_i        (steep_q),
    .color_i        (color_q),
    .busy_o         (shade_busy),
    .valid_o        (valid_o),
    .pix_x_o        (pix_x_o),
    .pix_y_o        (pix_y_o),
    .steep_o        (steep_o),
    .write_first_o  (write_first_o),
    .write_second_o (write_second_o),
    .first_o        (first_o),
    .second_o       (second_o),
    .last_o         (last_o)
  );

  always_comb begin
    status_o.len_zero      = len_q == '0;
    status_o.len_le1       = len_q[COORD_W-1:1] == '0;
    status_o.div_done      = div_done;
    status_o.interior_last = k_q == (len_q - COORD_W'(1));
    status_o.pipe_busy     = issue_valid_q | shade_busy;
  end

endmodule

>>> rtl/aalr_ctrl.sv
// ----------------------------------------------------------------------------
// aalr_ctrl: line sequencing controller
// Steps through setup, gradient division (not for a point), both endpoint
// pairs, the interior pairs (none for length one or less) and pipeline drain.
// ----------------------------------------------------------------------------
module aalr_ctrl import aalr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:        if (start_i) state_d = ST_SETUP;
      ST_SETUP:       state_d = status_i.len_zero ? ST_EMIT_FIRST : ST_DIVIDE;
      ST_DIVIDE:      if (status_i.div_done) state_d = ST_EMIT_FIRST;
      ST_EMIT_FIRST:  state_d = ST_EMIT_SECOND;
      ST_EMIT_SECOND: state_d = status_i.len_le1 ? ST_DRAIN : ST_INTERIOR;
      ST_INTERIOR:    if (status_i.interior_last) state_d = ST_DRAIN;
      ST_DRAIN:       if (!status_i.pipe_busy) state_d = ST_IDLE;
      default:        state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_SETUP:       cmd_o.div_start     = !status_i.len_zero;
      ST_DIVIDE:      cmd_o               = '0;
      ST_EMIT_FIRST:  cmd_o.emit_first    = 1'b1;
      ST_EMIT_SECOND: cmd_o.emit_second   = 1'b1;
      ST_INTERIOR:    cmd_o.emit_interior = 1'b1;
      ST_DRAIN:       cmd_o               = '0;
      default:        cmd_o               = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/antialiased_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_unit: anti-aliased line rasterizer top level
// Accepts two endpoints and a colour, emits the pixel-pair words of a line one per cycle.
// ----------------------------------------------------------------------------
// The first pair word follows start through setup, the bit-serial gradient
//   divider (skipped for a zero-length line), the issue register and both
//   shading stages.
// A line of major length L gives L + 1 words (2 for a point), one per cycle.
// Reset clears the controller and all valid flags; words are never stalled.
module antialiased_line_rasterizer_unit import aalr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  output logic   busy_o,
  input  coord_t x_start_i,
  input  coord_t y_start_i,
  input  coord_t x_stop_i,
  input  coord_t y_stop_i,
  input  chan_t  red_i,
  input  chan_t  green_i,
  input  chan_t  blue_i,
  output logic   valid_o,
  output coord_t pix_x_o,
  output coord_t pix_y_o,
  output logic   steep_o,
  output logic   write_first_o,
  output logic   write_second_o,
  output chan_t  first_red_o,
  output chan_t  first_green_o,
  output chan_t  first_blue_o,
  output chan_t  second_red_o,
  output chan_t  second_green_o,
  output chan_t  second_blue_o,
  output logic   last_o
);

  cmd_t    cmd;
  status_t status;
  rgb_t    first_col, second_col;

  // Controller: sequences setup, divide, endpoint pairs, interior pairs.
  aalr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Datapath: endpoint ordering, gradient, stepping and shading pipeline.
  aalr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .x_start_i      (x_start_i),
    .y_start_i      (y_start_i),
    .x_stop_i       (x_stop_i),
    .y_stop_i       (y_stop_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .valid_o        (valid_o),
    .pix_x_o        (pix_x_o),
    .pix_y_o        (pix_y_o),
    .steep_o        (steep_o),
    .write_first_o  (write_first_o),
    .write_second_o (write_second_o),
    .first_o        (first_col),
    .second_o       (second_col),
    .last_o         (last_o)
  );

  // Split the colour bundles onto their ports.
  assign first_red_o    = first_col.red;
  assign first_green_o  = first_col.green;
  assign first_blue_o   = first_col.blue;
  assign second_red_o   = second_col.red;
  assign second_green_o = second_col.green;
  assign second_blue_o  = second_col.blue;

  // An accepted line always makes the unit busy on the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("unit not busy after accepting a line");

  // The final word of a line is never directly followed by another word.
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o)
    else $error("word emitted right after last word");

  // An unwritten second pixel carries no colour.
  a_second_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !write_second_o |->
      second_red_o == '0 && second_green_o == '0 && second_blue_o == '0)
    else $error("colour on unwritten second pixel");

  // A written first pixel lies on the grid.
  a_first_on_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && write_first_o |->
      {1'b0, pix_x_o} < GRID_LIM && {1'b0, pix_y_o} < GRID_LIM)
    else $error("written first pixel off grid");

endmodule

>>> tb/antialiased_line_rasterizer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_checker: pixel-pair predictor and scoreboard
// Watches the command and result channels of the rasterizer. Each accepted
// line is expanded into its expected pixel-pair words, and each result word
// is compared against the oldest one still waiting.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer_checker import aalr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  coord_t      x_start_i,
  input  coord_t      y_start_i,
  input  coord_t      x_stop_i,
  input  coord_t      y_stop_i,
  input  chan_t       red_i,
  input  chan_t       green_i,
  input  chan_t       blue_i,
  input  logic        valid_o,
  input  coord_t      pix_x_o,
  input  coord_t      pix_y_o,
  input  logic        steep_o,
  input  logic        write_first_o,
  input  logic        write_second_o,
  input  chan_t       first_red_o,
  input  chan_t       first_green_o,
  input  chan_t       first_blue_o,
  input  chan_t       second_red_o,
  input  chan_t       second_green_o,
  input  chan_t       second_blue_o,
  input  logic        last_o,
  output int unsigned mismatch_count_o,
  output int unsigned pairs_pending_o
);

  typedef struct packed {
    coord_t px;
    coord_t py;
    logic   steep;
    logic   wr_first;
    logic   wr_second;
    rgb_t   first;
    rgb_t   second;
    logic   last;
  } pixel_pair_t;

  localparam int ONE_FIX = 65536;

  pixel_pair_t expected_pairs[$];
  int unsigned mismatches;

  assign mismatch_count_o = mismatches;
  assign pairs_pending_o  = expected_pairs.size();

  function automatic bit on_grid(int x, int y);
    return x >= 0 && y >= 0 && x < GRID_SIZE && y < GRID_SIZE;
  endfunction

  function automatic chan_t scale_chan(chan_t c, int cov);
    return chan_t'((int'(c) * cov) / 255);
  endfunction

  function automatic pixel_pair_t make_pair(bit steep, int major, int minor, int cov1,
                                            int cov2, rgb_t col, bit last);
    pixel_pair_t p;
    int px, py, qx, qy;
    bit w1, w2;
    px = steep ? minor : major;
    py = steep ? major : minor;
    qx = steep ? px + 1 : px;
    qy = steep ? py : py + 1;
    w1 = cov1 != 0 && on_grid(px, py);
    w2 = cov2 != 0 && on_grid(qx, qy);
    p.px           = px[COORD_W-1:0];
    p.py           = py[COORD_W-1:0];
    p.steep        = steep;
    p.wr_first     = w1;
    p.wr_second    = w2;
    p.first.red    = w1 ? scale_chan(col.red,   cov1) : '0;
    p.first.green  = w1 ? scale_chan(col.green, cov1) : '0;
    p.first.blue   = w1 ? scale_chan(col.blue,  cov1) : '0;
    p.second.red   = w2 ? scale_chan(col.red,   cov2) : '0;
    p.second.green = w2 ? scale_chan(col.green, cov2) : '0;
    p.second.blue  = w2 ? scale_chan(col.blue,  cov2) : '0;
    p.last         = last;
    return p;
  endfunction

  // Expand one line into endpoint pairs followed by the interior pairs.
  function automatic void expand_line(coord_t xa, coord_t ya, coord_t xb, coord_t yb,
                                      rgb_t col);
    int x0, y0, x1, y1, adx, ady, ma0, mi0, ma1, mi1, len, grad, pos, fl, frac, tmp;
    bit steep;
    x0 = (xa > GRID_SIZE - 1) ? GRID_SIZE - 1 : int'(xa);
    y0 = (ya > GRID_SIZE - 1) ? GRID_SIZE - 1 : int'(ya);
    x1 = (xb > GRID_SIZE - 1) ? GRID_SIZE - 1 : int'(xb);
    y1 = (yb > GRID_SIZE - 1) ? GRID_SIZE - 1 : int'(yb);
    adx = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady = (y1 > y0) ? y1 - y0 : y0 - y1;
    steep = adx <= ady;
    if (steep) begin
      ma0 = y0; mi0 = x0; ma1 = y1; mi1 = x1;
    end else begin
      ma0 = x0; mi0 = y0; ma1 = x1; mi1 = y1;
    end
    if (ma1 < ma0) begin
      tmp = ma0; ma0 = ma1; ma1 = tmp;
      tmp = mi0; mi0 = mi1; mi1 = tmp;
    end
    len = ma1 - ma0;
    if (len == 0) begin
      // point: first pair one row above (clamped at row 0), second on it
      expected_pairs.push_back(make_pair(steep, (ma0 > 0) ? ma0 - 1 : 0, mi0,
                                         COV_HALF, 0, col, 1'b0));
      expected_pairs.push_back(make_pair(steep, ma0, mi0, COV_HALF, 0, col, 1'b1));
      return;
    end
    // signed division truncates toward zero, as the hardware gradient does
    grad = ((mi1 - mi0) * ONE_FIX) / len;
    expected_pairs.push_back(make_pair(steep, ma0, mi0, COV_HALF, 0, col, 1'b0));
    expected_pairs.push_back(make_pair(steep, ma1, mi1, COV_HALF, 0, col, len == 1));
    for (int k = 1; k < len; k++) begin
      pos  = mi0 * ONE_FIX + k * grad;
      fl   = pos >>> FRAC_W;
      frac = pos & (ONE_FIX - 1);
      expected_pairs.push_back(make_pair(steep, ma0 + k, fl,
                                         ((ONE_FIX - frac) * 255) >>> FRAC_W,
                                         (frac * 255) >>> FRAC_W, col, k == len - 1));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_pair_t got, want;
    if (!rst_ni) begin
      expected_pairs.delete();
      mismatches = 0;
    end else begin
      if (valid_o) begin
        got = '{pix_x_o, pix_y_o, steep_o, write_first_o, write_second_o,
                '{first_red_o, first_green_o, first_blue_o},
                '{second_red_o, second_green_o, second_blue_o}, last_o};
        if (expected_pairs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected pair word x=%0d y=%0d last=%0b", $realtime,
                     got.px, got.py, got.last);
        end else begin
          want = expected_pairs.pop_front();
          if (got.px !== want.px || got.py !== want.py || got.steep !== want.steep ||
              got.wr_first !== want.wr_first || got.wr_second !== want.wr_second ||
              got.first !== want.first || got.second !== want.second ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: pair mismatch", $realtime);
              $display("  want x=%0d y=%0d steep=%0b wr=%0b%0b c1=%h c2=%h last=%0b",
                       want.px, want.py, want.steep, want.wr_first, want.wr_second,
                       want.first, want.second, want.last);
              $display("  got  x=%0d y=%0d steep=%0b wr=%0b%0b c1=%h c2=%h last=%0b",
                       got.px, got.py, got.steep, got.wr_first, got.wr_second,
                       got.first, got.second, got.last);
            end
          end
        end
      end
      if (start_i && !busy_o)
        expand_line(x_start_i, y_start_i, x_stop_i, y_stop_i,
                    '{red_i, green_i, blue_i});
    end
  end

endmodule

>>> tb/antialiased_line_rasterizer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_unit_tb: line rasterizer testbench
// Sends directed lines (points, axis-aligned, diagonal, unit length, reversed
// and out-of-grid endpoints, color extremes) and then random lines under
// several sender idle rates. The checker predicts every pixel-pair word.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer_unit_tb;
  import aalr_pkg::*;

  logic   clk_i   = 1'b0;
  logic   rst_ni  = 1'b0;
  logic   start_i = 1'b0;
  coord_t x_start_i = '0;
  coord_t y_start_i = '0;
  coord_t x_stop_i  = '0;
  coord_t y_stop_i  = '0;
  chan_t  red_i     = '0;
  chan_t  green_i   = '0;
  chan_t  blue_i    = '0;

  logic   busy_o, valid_o, steep_o, write_first_o, write_second_o, last_o;
  coord_t pix_x_o, pix_y_o;
  chan_t  first_red_o, first_green_o, first_blue_o;
  chan_t  second_red_o, second_green_o, second_blue_o;

  int unsigned mismatch_count, pairs_pending;
  // chance in percent that the sender skips a given cycle
  int unsigned idle_pct = 0;

  always #2 clk_i = ~clk_i;

  antialiased_line_rasterizer_unit dut (.*);

  antialiased_line_rasterizer_checker checker_i (
    .*,
    .mismatch_count_o(mismatch_count),
    .pairs_pending_o (pairs_pending)
  );

  // Hold start high until the block takes the word. Start stays high across
  // back-to-back words so it never gets two updates in one step.
  task automatic send_line(coord_t xa, coord_t ya, coord_t xb, coord_t yb,
                           chan_t r, chan_t g, chan_t b);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 200)
      gap++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    x_start_i <= xa;
    y_start_i <= ya;
    x_stop_i  <= xb;
    y_stop_i  <= yb;
    red_i     <= r;
    green_i   <= g;
    blue_i    <= b;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Mostly on-grid coordinates, a fifth of them anywhere in the 6-bit range
  // so that clamping at the grid edge gets exercised.
  function automatic coord_t pick_coord();
    return ($urandom_range(4) == 0) ? coord_t'($urandom_range(63))
                                    : coord_t'($urandom_range(GRID_SIZE - 1));
  endfunction

  task automatic send_random_line();
    coord_t xa, ya, xb, yb;
    chan_t r, g, b;
    int unsigned kind;
    xa = pick_coord();
    ya = pick_coord();
    kind = $urandom_range(99);
    if (kind < 10) begin
      // point
      xb = xa;
      yb = ya;
    end else if (kind < 30) begin
      // short line, unit length common
      xb = coord_t'((int'(xa) + $urandom_range(4) + 62) % 64);
      yb = coord_t'((int'(ya) + $urandom_range(4) + 62) % 64);
    end else begin
      xb = pick_coord();
      yb = pick_coord();
    end
    if ($urandom_range(9) == 0) begin
      r = 8'hff; g = 8'hff; b = 8'hff;
    end else begin
      r = chan_t'($urandom_range(255));
      g = chan_t'($urandom_range(255));
      b = chan_t'($urandom_range(255));
    end
    send_line(xa, ya, xb, yb, r, g, b);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines: points, axes, diagonals, reversed order, unit length,
    // clamped coordinates, and the color extremes.
    send_line(0, 0, 0, 0, 8'hff, 8'hff, 8'hff);
    send_line(39, 39, 39, 39, 8'hff, 8'h00, 8'h80);
    send_line(5, 10, 5, 10, 8'h12, 8'h34, 8'h56);
    send_line(0, 0, 39, 39, 8'hff, 8'hff, 8'hff);
    send_line(39, 0, 0, 39, 8'h00, 8'h00, 8'h00);
    send_line(0, 0, 39, 0, 8'hff, 8'h7f, 8'h01);
    send_line(0, 0, 0, 39, 8'h01, 8'hfe, 8'hff);
    send_line(39, 20, 0, 20, 8'haa, 8'h55, 8'hff);
    send_line(20, 39, 20, 0, 8'h55, 8'haa, 8'h00);
    send_line(3, 3, 4, 3, 8'hff, 8'hff, 8'hff);
    send_line(3, 3, 3, 4, 8'hff, 8'hff, 8'hff);
    send_line(4, 4, 3, 3, 8'hc0, 8'h30, 8'h0f);
    send_line(0, 0, 39, 1, 8'hff, 8'hff, 8'hff);
    send_line(0, 38, 39, 39, 8'hff, 8'hff, 8'hff);
    send_line(38, 0, 39, 39, 8'hff, 8'hff, 8'hff);
    send_line(10, 0, 0, 39, 8'h80, 8'h80, 8'h80);
    send_line(63, 63, 0, 0, 8'hff, 8'hff, 8'hff);
    send_line(40, 0, 0, 40, 8'h10, 8'h20, 8'h30);
    send_line(63, 63, 63, 63, 8'hff, 8'hff, 8'hff);
    send_line(32, 16, 8, 4, 8'hfe, 8'hfd, 8'hfb);
    send_line(2, 1, 37, 30, 8'hf7, 8'hef, 8'hdf);
    send_line(0, 21, 39, 42, 8'hbf, 8'h7f, 8'h40);

    // Random lines in phases of sender idling: none, heavy, light, none.
    idle_pct = 0;
    repeat (20) send_random_line();
    idle_pct = 87;
    repeat (20) send_random_line();
    idle_pct = 16;
    repeat (20) send_random_line();
    idle_pct = 0;
    repeat (20) send_random_line();
    start_i <= 1'b0;

    // Drain, then allow a full line time for any stray word to show up.
    while (pairs_pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    if (mismatch_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
